/* hdl/cpbb_pkg.sv */
// cpbb_pkg: shared constants, the token type carried along the cell chain,
// and the position clamp used at the pixel input.
// No dependencies.
package cpbb_pkg;

	localparam int PALETTE_ENTRIES = 128;
	localparam int MAX_IMAGE_SIDE  = 1024;

	localparam int COLOR_W = 24;
	localparam int CHAN_W  = 8;
	localparam int POS_W   = 10;
	localparam int COUNT_W = 21;
	localparam int INDEX_W = 7;
	localparam int ENTRY_W = $clog2(PALETTE_ENTRIES);
	localparam int USED_W  = $clog2(PALETTE_ENTRIES + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// one pixel on its way through the chain, with its result once resolved
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [POS_W-1:0]   x;
		logic [POS_W-1:0]   y;
		logic               done;
		logic               is_new;
		logic [ENTRY_W-1:0] idx;
		logic [COUNT_W-1:0] count;
		logic [POS_W-1:0]   left;
		logic [POS_W-1:0]   top;
		logic [POS_W-1:0]   right;
		logic [POS_W-1:0]   bottom;
	} token_t;

	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
		if (32'(p) >= MAX_IMAGE_SIDE)
			return POS_W'(MAX_IMAGE_SIDE - 1);
		return p;
	endfunction

endpackage

/* hdl/cpbb_cell.sv */
// cpbb_cell: one palette entry plus one chain stage. Matches or claims the
// entry for the passing pixel and forwards the pixel to the next cell.
// Depends on cpbb_pkg.
module cpbb_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [cpbb_pkg::ENTRY_W-1:0]  idx,
	input  logic [cpbb_pkg::USED_W-1:0]   used_cnt,
	input  logic                          in_vld,
	input  cpbb_pkg::token_t              in_tok,
	output logic                          out_vld,
	output cpbb_pkg::token_t              out_tok,
	output logic                          claim
);
	import cpbb_pkg::*;

	logic [COLOR_W-1:0] color_q;
	logic [COUNT_W-1:0] count_q;
	logic [POS_W-1:0]   left_q, top_q, right_q, bottom_q;
	logic               vld_q;
	token_t             tok_q;

	logic               used;
	logic               hit;
	logic [COUNT_W-1:0] count_nx;
	logic [POS_W-1:0]   left_nx, top_nx, right_nx, bottom_nx;
	token_t             tok_nx;

	// entries fill in index order, so the fill count tells which are live
	assign used  = USED_W'(idx) < used_cnt;
	assign hit   = in_vld && !in_tok.done && used && (in_tok.color == color_q);
	assign claim = in_vld && !in_tok.done && !used;

	always_comb begin
		if (hit) begin
			count_nx  = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
			left_nx   = (in_tok.x < left_q)   ? in_tok.x : left_q;
			right_nx  = (in_tok.x > right_q)  ? in_tok.x : right_q;
			top_nx    = (in_tok.y < top_q)    ? in_tok.y : top_q;
			bottom_nx = (in_tok.y > bottom_q) ? in_tok.y : bottom_q;
		end else begin
			count_nx  = COUNT_W'(1);
			left_nx   = in_tok.x;
			right_nx  = in_tok.x;
			top_nx    = in_tok.y;
			bottom_nx = in_tok.y;
		end
	end

	always_comb begin
		tok_nx = in_tok;
		if (hit || claim) begin
			tok_nx.done   = 1'b1;
			tok_nx.is_new = claim;
			tok_nx.idx    = idx;
			tok_nx.count  = count_nx;
			tok_nx.left   = left_nx;
			tok_nx.top    = top_nx;
			tok_nx.right  = right_nx;
			tok_nx.bottom = bottom_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_nx;
			if (claim)
				color_q <= in_tok.color;
			if (hit || claim) begin
				count_q  <= count_nx;
				left_q   <= left_nx;
				top_q    <= top_nx;
				right_q  <= right_nx;
				bottom_q <= bottom_nx;
			end
		end
	end

	assign out_vld = vld_q;
	assign out_tok = tok_q;

endmodule

/* hdl/color_palette_bbox_builder.sv */
// Pipeline from pixel transaction to result: one input register plus one
// stage per palette cell.
// Throughput: one pixel per cycle while result_ready is high; the whole
// cell chain holds when the result register is full and not taken.
// Reset: asynchronous, clears the fill count and all stage valids; the
// palette is empty at once, with no clearing pass.
module color_palette_bbox_builder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [cpbb_pkg::CHAN_W-1:0]   red,
	input  logic [cpbb_pkg::CHAN_W-1:0]   green,
	input  logic [cpbb_pkg::CHAN_W-1:0]   blue,
	input  logic [cpbb_pkg::POS_W-1:0]    x_position,
	input  logic [cpbb_pkg::POS_W-1:0]    y_position,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [cpbb_pkg::INDEX_W-1:0]  entry_index,
	output logic                          is_new,
	output logic                          table_full,
	output logic [cpbb_pkg::COUNT_W-1:0]  pixel_count,
	output logic [cpbb_pkg::POS_W-1:0]    box_left,
	output logic [cpbb_pkg::POS_W-1:0]    box_top,
	output logic [cpbb_pkg::POS_W-1:0]    box_right,
	output logic [cpbb_pkg::POS_W-1:0]    box_bottom
);
	import cpbb_pkg::*;

	logic                       adv;
	logic [PALETTE_ENTRIES:0]   tok_vld;
	token_t                     tok [PALETTE_ENTRIES+1];
	logic [PALETTE_ENTRIES-1:0] claims;
	logic [USED_W-1:0]          used_q;
	logic                       vld_s0_q;
	token_t                     tok_s0_q;
	token_t                     tok_in;
	token_t                     last;

	assign adv         = !tok_vld[PALETTE_ENTRIES] || result_ready;
	assign pixel_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0_q <= 1'b0;
			used_q   <= '0;
		end else if (adv) begin
			vld_s0_q <= pixel_valid;
			// at most one cell claims in a cycle
			if (|claims)
				used_q <= used_q + 1'b1;
		end
	end

	always_comb begin
		tok_in       = '0;
		tok_in.color = {red, green, blue};
		tok_in.x     = clamp_pos(x_position);
		tok_in.y     = clamp_pos(y_position);
	end

	always_ff @(posedge clk) begin
		if (adv && pixel_valid) begin
			tok_s0_q <= tok_in;
		end
	end

	assign tok_vld[0] = vld_s0_q;
	assign tok[0]     = tok_s0_q;

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		cpbb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.idx      (ENTRY_W'(i)),
			.used_cnt (used_q),
			.in_vld   (tok_vld[i]),
			.in_tok   (tok[i]),
			.out_vld  (tok_vld[i+1]),
			.out_tok  (tok[i+1]),
			.claim    (claims[i])
		);
	end

	// a pixel that leaves the chain unresolved found no free entry
	assign last         = tok[PALETTE_ENTRIES];
	assign result_valid = tok_vld[PALETTE_ENTRIES];
	assign table_full   = !last.done;
	assign entry_index  = last.done ? INDEX_W'(last.idx) : '0;
	assign is_new       = last.done && last.is_new;
	assign pixel_count  = last.done ? last.count  : '0;
	assign box_left     = last.done ? last.left   : '0;
	assign box_top      = last.done ? last.top    : '0;
	assign box_right    = last.done ? last.right  : '0;
	assign box_bottom   = last.done ? last.bottom : '0;

endmodule

/* hdl/cpbb_checker.sv */
// cpbb_checker: port-level checks on the palette builder, attached by bind.
// Depends on cpbb_pkg and color_palette_bbox_builder.
module cpbb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pixel_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [cpbb_pkg::INDEX_W-1:0]  entry_index,
	input logic                          is_new,
	input logic                          table_full,
	input logic [cpbb_pkg::COUNT_W-1:0]  pixel_count,
	input logic [cpbb_pkg::POS_W-1:0]    box_left,
	input logic [cpbb_pkg::POS_W-1:0]    box_top,
	input logic [cpbb_pkg::POS_W-1:0]    box_right,
	input logic [cpbb_pkg::POS_W-1:0]    box_bottom
);
	import cpbb_pkg::*;

	// a stalled result transaction stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(pixel_count)
			&& $stable(entry_index) && $stable(table_full))
		else $error("result changed while stalled");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && table_full |-> !is_new && pixel_count == '0
			&& entry_index == '0 && box_right == '0 && box_bottom == '0)
		else $error("table full result not cleared");

	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_new |-> pixel_count == COUNT_W'(1)
			&& box_left == box_right && box_top == box_bottom)
		else $error("new entry without single pixel box");

	a_box: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !table_full |-> pixel_count != '0
			&& box_left <= box_right && box_top <= box_bottom)
		else $error("inconsistent box or count");

	// the chain keeps moving whenever the result side is free
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid || result_ready |-> pixel_ready)
		else $error("input stalled with free result slot");

endmodule

bind color_palette_bbox_builder cpbb_checker u_cpbb_checker (.*);
